[design/rk4pa_pkg.sv]
// Shared types and constants for the RK4 particle advection stage.
// No dependencies.
package rk4pa_pkg;

  localparam int INDEX_W = 10;
  localparam int COORD_W = 32;
  localparam int DIM_MAX = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int MAX_PARTICLES_DEF = 1024;
  localparam int DIMENSIONS_DEF = 3;

  // Substep codes (value of the stage register)
  localparam logic [1:0] STAGE0 = 2'd0;
  localparam logic [1:0] STAGE1 = 2'd1;
  localparam logic [1:0] STAGE2 = 2'd2;
  localparam logic [1:0] STAGE3 = 2'd3;

  // Configuration register indexes
  localparam logic CFG_STAGE     = 1'b0;
  localparam logic CFG_TIME_STEP = 1'b1;

  // Velocity operand of one axis, in sign/magnitude form, with the axis position
  typedef struct packed {
    logic        neg;
    logic [32:0] mag;
    logic [31:0] pos;
  } lane_t;

  // Classified word handed from front to back
  typedef struct packed {
    logic [INDEX_W-1:0]       index;
    logic [INDEX_W-1:0]       row;
    logic [1:0]               op;
    lane_t [DIM_MAX-1:0]      lane;
  } entry_t;

endpackage

[design/rk4_particle_advection_stage_unit.sv]
// RK4 particle advection stage, top level: ports, config registers and
// the front / queue / back split. Uses rk4pa_pkg, rk4pa_front, rk4pa_queue, rk4pa_back.
//
// One classic Runge-Kutta substep per pass over the particles. Write
// "stage" (0..3) and "time_step" (dt, unsigned Q16.16) with the block idle,
// then stream particles in: each input word carries the index, position
// and old/new velocity; each output word carries the index and the updated
// position (Q16.16, rounded half away from zero, saturated). A stage 0
// pass must write a particle's row before later stages read it. Rows are
// particle_index modulo MAX_PARTICLES. Throughput is one word per clock
// while the output is not stalled, set by one 33x32 slope multiplier per
// axis and one read and one write port on each per-axis table RAM. On
// the way to output valid, a word passes the front register, which loads
// at the accepting edge, then the queue and the five back-end registers.
// With DIMENSIONS = 2, z inputs are ignored and next_z is zero. No
// clearing pass is needed after reset.
module rk4_particle_advection_stage_unit #(
  parameter int MAX_PARTICLES = rk4pa_pkg::MAX_PARTICLES_DEF,
  parameter int DIMENSIONS    = rk4pa_pkg::DIMENSIONS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  // Config write channel: index 0 stage, 1 time_step
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_index,
  input  logic [31:0]   cfg_data,
  // Input words
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // tdata from bit 0: particle_index[10], pos_x, pos_y, pos_z,
  // old_vel_x, old_vel_y, old_vel_z, new_vel_x, new_vel_y, new_vel_z
  // (32 each), 6 zero bits
  input  logic [303:0]  s_axis_tdata,
  // Output words
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // tdata from bit 0: result_index[10], next_x, next_y, next_z (32 each),
  // 6 zero bits
  output logic [111:0]  m_axis_tdata
);

  localparam int ROWS = (MAX_PARTICLES < 1024) ? MAX_PARTICLES : 1024;

  logic [1:0]  stage;
  logic [31:0] time_step;

  logic [rk4pa_pkg::DIM_MAX-1:0][31:0] in_pos, in_old, in_new;

  logic              f_valid, f_ready;
  rk4pa_pkg::entry_t f_entry;
  logic              q_valid, q_pop;
  rk4pa_pkg::entry_t q_entry;

  logic [rk4pa_pkg::INDEX_W-1:0] res_index;
  logic [31:0] res_next [DIMENSIONS];
  logic [31:0] res_z;

  // Config registers; always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage     <= rk4pa_pkg::STAGE0;
      time_step <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rk4pa_pkg::CFG_STAGE:     stage     <= cfg_data[1:0];
        rk4pa_pkg::CFG_TIME_STEP: time_step <= cfg_data;
        default:                  ;
      endcase
    end
  end

  // Unpack input word
  always_comb begin
    for (int d = 0; d < rk4pa_pkg::DIM_MAX; d++) begin
      in_pos[d] = s_axis_tdata[10 + 32*d +: 32];
      in_old[d] = s_axis_tdata[106 + 32*d +: 32];
      in_new[d] = s_axis_tdata[202 + 32*d +: 32];
    end
  end

  rk4pa_front #(.MAX_PARTICLES(MAX_PARTICLES), .DIMENSIONS(DIMENSIONS)) u_front (
    .clk(clk), .rst(rst), .stage(stage),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_index(s_axis_tdata[9:0]),
    .in_pos(in_pos), .in_old(in_old), .in_new(in_new),
    .out_valid(f_valid), .out_ready(f_ready), .out_entry(f_entry));

  rk4pa_queue u_queue (
    .clk(clk), .rst(rst),
    .push_valid(f_valid), .push_ready(f_ready), .push_entry(f_entry),
    .pop_valid(q_valid), .pop(q_pop), .pop_entry(q_entry));

  rk4pa_back #(.DIMENSIONS(DIMENSIONS), .ROWS(ROWS)) u_back (
    .clk(clk), .rst(rst), .time_step(time_step),
    .q_valid(q_valid), .q_entry(q_entry), .q_pop(q_pop),
    .m_valid(m_axis_tvalid), .m_ready(m_axis_tready),
    .m_index(res_index), .m_next(res_next));

  if (DIMENSIONS == 3) begin : g_z3
    assign res_z = res_next[2];
  end else begin : g_z2
    assign res_z = '0;
  end

  assign m_axis_tdata = {6'd0, res_z, res_next[1], res_next[0], res_index};

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result word changed while waiting");

endmodule

[design/rk4pa_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module rk4pa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/rk4pa_front.sv]
// Front end: accepts input words, picks the velocity operand for the
// current substep and folds the particle index onto a table row. Uses rk4pa_pkg.
module rk4pa_front #(
  parameter int MAX_PARTICLES = rk4pa_pkg::MAX_PARTICLES_DEF,
  parameter int DIMENSIONS    = rk4pa_pkg::DIMENSIONS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic [1:0]                                    stage,
  input  logic                                          in_valid,
  output logic                                          in_ready,
  input  logic [rk4pa_pkg::INDEX_W-1:0]                 in_index,
  input  logic [rk4pa_pkg::DIM_MAX-1:0][31:0]           in_pos,
  input  logic [rk4pa_pkg::DIM_MAX-1:0][31:0]           in_old,
  input  logic [rk4pa_pkg::DIM_MAX-1:0][31:0]           in_new,
  output logic                                          out_valid,
  input  logic                                          out_ready,
  output rk4pa_pkg::entry_t                             out_entry
);

  localparam int ROWS  = (MAX_PARTICLES < 1024) ? MAX_PARTICLES : 1024;
  localparam int SHIFT = 20;
  localparam int RECIP = ((1 << SHIFT) + ROWS - 1) / ROWS;
  localparam logic [10:0] ROWS_C = 11'(ROWS);

  logic                                  f_valid;
  logic [rk4pa_pkg::INDEX_W-1:0]         f_index;
  logic [rk4pa_pkg::INDEX_W-1:0]         f_quot;
  logic [1:0]                            f_op;
  rk4pa_pkg::lane_t [rk4pa_pkg::DIM_MAX-1:0] f_lane;

  rk4pa_pkg::lane_t [rk4pa_pkg::DIM_MAX-1:0] lane_next;
  logic [32:0]                           sum [rk4pa_pkg::DIM_MAX];
  logic [30:0]                           quot_prod;
  logic [rk4pa_pkg::INDEX_W-1:0]         quot_next;
  logic [20:0]                           back_prod;

  assign in_ready = !f_valid || out_ready;

  always_comb begin
    for (int d = 0; d < rk4pa_pkg::DIM_MAX; d++) begin
      lane_next[d] = '0;
      sum[d] = '0;
      if (d < DIMENSIONS) begin
        unique case (stage)
          rk4pa_pkg::STAGE0: sum[d] = {in_old[d][31], in_old[d]};
          rk4pa_pkg::STAGE3: sum[d] = {in_new[d][31], in_new[d]};
          default:           sum[d] = {in_old[d][31], in_old[d]} +
                                      {in_new[d][31], in_new[d]};
        endcase
        lane_next[d].neg = sum[d][32];
        lane_next[d].mag = sum[d][32] ? (33'd0 - sum[d]) : sum[d];
        lane_next[d].pos = in_pos[d];
      end
    end
  end

  // Quotient by reciprocal multiply; exact for 10-bit indexes
  assign quot_prod = 31'(in_index) * 31'(RECIP);
  assign quot_next = (MAX_PARTICLES < 1024) ? quot_prod[SHIFT +: rk4pa_pkg::INDEX_W]
                                            : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (in_ready) begin
      f_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      f_index <= in_index;
      f_quot  <= quot_next;
      f_op    <= stage;
      f_lane  <= lane_next;
    end
  end

  assign back_prod       = 21'(f_quot) * 21'(ROWS_C);
  assign out_valid       = f_valid;
  assign out_entry.index = f_index;
  assign out_entry.row   = f_index - back_prod[rk4pa_pkg::INDEX_W-1:0];
  assign out_entry.op    = f_op;
  assign out_entry.lane  = f_lane;

endmodule

[design/rk4pa_queue.sv]
// Short FIFO of classified words between front and back.
// Uses rk4pa_pkg.
module rk4pa_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  rk4pa_pkg::entry_t push_entry,
  output logic              pop_valid,
  input  logic              pop,
  output rk4pa_pkg::entry_t pop_entry
);

  localparam int PTR_W = $clog2(rk4pa_pkg::QUEUE_DEPTH);

  rk4pa_pkg::entry_t mem [rk4pa_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [PTR_W:0]    count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = count < (PTR_W+1)'(rk4pa_pkg::QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_entry  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (PTR_W+1)'(rk4pa_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> !do_pop)
    else $error("pop from empty queue");

endmodule

[design/rk4pa_back.sv]
// Back end: slope multiply, stage table access, position sum and rounded
// division, in a five-register pipeline. Uses rk4pa_pkg and rk4pa_ram.
module rk4pa_back #(
  parameter int DIMENSIONS = rk4pa_pkg::DIMENSIONS_DEF,
  parameter int ROWS       = rk4pa_pkg::MAX_PARTICLES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [31:0]                   time_step,
  input  logic                          q_valid,
  input  rk4pa_pkg::entry_t             q_entry,
  output logic                          q_pop,
  output logic                          m_valid,
  input  logic                          m_ready,
  output logic [rk4pa_pkg::INDEX_W-1:0] m_index,
  output logic [31:0]                   m_next [DIMENSIONS]
);

  localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [33:0] RECIP3  = 34'h2AAAAAAAB;   // ceil(2^35 / 3)
  localparam logic [35:0] Y_LIMIT = 36'd6442450947;  // 3 * (2^31 + 1)

  logic en;
  logic a_valid, b_valid, c_valid, d_valid;
  logic [1:0] a_op, b_op, c_op, d_op;
  logic [rk4pa_pkg::INDEX_W-1:0] a_index, b_index, c_index, d_index;
  logic [rk4pa_pkg::INDEX_W-1:0] a_row;

  assign en    = !m_valid || m_ready;
  assign q_pop = en && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
      m_valid <= 1'b0;
    end else if (en) begin
      a_valid <= q_valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
      d_valid <= c_valid;
      m_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_op    <= q_entry.op;
      a_index <= q_entry.index;
      a_row   <= q_entry.row;
      b_op    <= a_op;
      b_index <= a_index;
      c_op    <= b_op;
      c_index <= b_index;
      d_op    <= c_op;
      d_index <= c_index;
      m_index <= d_index;
    end
  end

  for (genvar d = 0; d < DIMENSIONS; d++) begin : g_lane
    logic [64:0] a_prod;
    logic        a_neg;
    logic [31:0] a_pos;
    logic [31:0] rd_start, rd_k0, rd_k1, rd_k2;
    logic [65:0] rnd;
    logic [49:0] r;
    logic [31:0] k;
    logic        half;
    logic [31:0] b_start, b_k, b_k0, b_k1, b_k2;
    logic [36:0] n_sum;
    logic [36:0] c_n;
    logic [36:0] abs_n;
    logic [35:0] y;
    logic [35:0] div_val;
    logic        d_neg;
    logic [35:0] d_val;
    logic [66:0] prod6;
    logic [35:0] q;
    logic [31:0] sat_q;
    logic        wr_a;

    // A: magnitude times dt, table read issued at the pop
    always_ff @(posedge clk) begin
      if (en) begin
        a_prod <= 65'(q_entry.lane[d].mag) * 65'(time_step);
        a_neg  <= q_entry.lane[d].neg;
        a_pos  <= q_entry.lane[d].pos;
      end
    end

    rk4pa_ram #(.WIDTH(32), .DEPTH(ROWS)) u_start (
      .clk(clk), .we(wr_a && (a_op == rk4pa_pkg::STAGE0)),
      .waddr(a_row[AW-1:0]), .wdata(a_pos),
      .re(en), .raddr(q_entry.row[AW-1:0]), .rdata(rd_start));
    rk4pa_ram #(.WIDTH(32), .DEPTH(ROWS)) u_k0 (
      .clk(clk), .we(wr_a && (a_op == rk4pa_pkg::STAGE0)),
      .waddr(a_row[AW-1:0]), .wdata(k),
      .re(en), .raddr(q_entry.row[AW-1:0]), .rdata(rd_k0));
    rk4pa_ram #(.WIDTH(32), .DEPTH(ROWS)) u_k1 (
      .clk(clk), .we(wr_a && (a_op == rk4pa_pkg::STAGE1)),
      .waddr(a_row[AW-1:0]), .wdata(k),
      .re(en), .raddr(q_entry.row[AW-1:0]), .rdata(rd_k1));
    rk4pa_ram #(.WIDTH(32), .DEPTH(ROWS)) u_k2 (
      .clk(clk), .we(wr_a && (a_op == rk4pa_pkg::STAGE2)),
      .waddr(a_row[AW-1:0]), .wdata(k),
      .re(en), .raddr(q_entry.row[AW-1:0]), .rdata(rd_k2));

    assign wr_a = en && a_valid;

    // Slope: round half away, >>16 (or >>17 for the averaged velocity)
    always_comb begin
      half = (a_op == rk4pa_pkg::STAGE1) || (a_op == rk4pa_pkg::STAGE2);
      rnd  = {1'b0, a_prod} + (half ? (66'd1 << 16) : (66'd1 << 15));
      r    = half ? {1'b0, rnd[65:17]} : rnd[65:16];
      if (a_neg) begin
        k = (r > 50'h80000000) ? 32'h80000000 : (32'd0 - r[31:0]);
      end else begin
        k = (r > 50'h7FFFFFFF) ? 32'h7FFFFFFF : r[31:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        b_start <= (a_op == rk4pa_pkg::STAGE0) ? a_pos : rd_start;
        b_k     <= k;
        b_k0    <= rd_k0;
        b_k1    <= rd_k1;
        b_k2    <= rd_k2;
      end
    end

    // Position numerator, exact
    always_comb begin
      unique case (b_op)
        rk4pa_pkg::STAGE0, rk4pa_pkg::STAGE1:
          n_sum = (37'(signed'(b_start)) <<< 1) + 37'(signed'(b_k));
        rk4pa_pkg::STAGE2:
          n_sum = 37'(signed'(b_start)) + 37'(signed'(b_k));
        default:
          n_sum = 37'(signed'(b_start)) * 37'sd6 + 37'(signed'(b_k0)) +
                  (37'(signed'(b_k1)) <<< 1) + (37'(signed'(b_k2)) <<< 1) +
                  37'(signed'(b_k));
      endcase
    end

    always_ff @(posedge clk) begin
      if (en) c_n <= n_sum;
    end

    // Magnitude and first rounding step; /6 becomes (m+3)>>1 then /3
    always_comb begin
      abs_n = c_n[36] ? (37'd0 - c_n) : c_n;
      y     = 36'((abs_n + 37'd3) >> 1);
      unique case (c_op)
        rk4pa_pkg::STAGE0, rk4pa_pkg::STAGE1: div_val = 36'((abs_n + 37'd1) >> 1);
        rk4pa_pkg::STAGE2:                    div_val = abs_n[35:0];
        default:                              div_val = (y > Y_LIMIT) ? Y_LIMIT : y;
      endcase
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_neg <= c_n[36];
        d_val <= div_val;
      end
    end

    // Divide by three via reciprocal for stage 3, then saturate
    always_comb begin
      prod6 = 67'(d_val[32:0]) * 67'(RECIP3);
      q = (d_op == rk4pa_pkg::STAGE3) ? {4'd0, prod6[66:35]} : d_val;
      if (d_neg) begin
        sat_q = (q > 36'h80000000) ? 32'h80000000 : (32'd0 - q[31:0]);
      end else begin
        sat_q = (q > 36'h7FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) m_next[d] <= sat_q;
    end
  end

  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    (d_valid && !en) |=> d_valid)
    else $error("pipeline dropped a word during stall");

  a_pop_only_on_advance: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (en && q_valid))
    else $error("pop while back end stalled");

endmodule

[test/rk4_particle_advection_stage_unit_tb.sv]
// Self-checking testbench for the RK4 particle advection stage unit.
// Depends on rk4pa_pkg and the rk4_particle_advection_stage_unit RTL.
// Predicts every output word, compares it field by field, idles both sides.
module rk4_particle_advection_stage_unit_tb;

  localparam int NPART = 1024;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [9:0] index;
    logic signed [2:0][31:0] pos;
    logic signed [2:0][31:0] vold;
    logic signed [2:0][31:0] vnew;
  } particle_t;

  typedef struct packed {
    logic [9:0] index;
    logic [2:0][31:0] nxt;
  } position_t;

  logic clk, rst;
  logic cfg_valid, cfg_ready, cfg_index;
  logic [31:0] cfg_data;
  logic s_axis_tvalid, s_axis_tready;
  logic [303:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready;
  logic [111:0] m_axis_tdata;

  rk4_particle_advection_stage_unit dut (.*);

  // Shadow of the per-particle table and the config registers
  logic signed [31:0] start_tab [NPART*3];
  logic signed [31:0] k0_tab [NPART*3];
  logic signed [31:0] k1_tab [NPART*3];
  logic signed [31:0] k2_tab [NPART*3];
  logic [1:0] cur_stage;
  logic [31:0] cur_dt;

  particle_t pending_q[$];
  position_t expected_pos_q[$];
  bit driver_busy;
  int mismatches = 0;
  int watchdog;
  int hold_req = 0; // bumped by the stimulus to ask for a long receiver stall
  bit in_acc;       // input word accepted at the last rising edge

  function automatic logic signed [63:0] sat32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // s*dt >> sh, rounded half away from zero, saturated
  function automatic logic signed [63:0] scale_by_dt(logic signed [63:0] s, int sh);
    logic [127:0] mag, prod;
    logic signed [63:0] r;
    mag = (s < 0) ? 128'(-s) : 128'(s);
    prod = (mag * cur_dt + (128'd1 << (sh - 1))) >> sh;
    if (prod > 128'h7fffffffffffffff) prod = 128'h7fffffffffffffff;
    r = (s < 0) ? -$signed(64'(prod)) : $signed(64'(prod));
    return sat32(r);
  endfunction

  function automatic logic signed [63:0] div_nearest(logic signed [63:0] n, int d);
    logic [63:0] mag;
    logic signed [63:0] q;
    mag = (n < 0) ? 64'(-n) : 64'(n);
    q = $signed((mag + d / 2) / d);
    return sat32((n < 0) ? -q : q);
  endfunction

  function automatic position_t advance_particle(particle_t p);
    position_t o;
    int at;
    logic signed [63:0] pos, vo, vn, st, k, nx;
    o.index = p.index;
    for (int d = 0; d < 3; d++) begin
      at = int'(p.index) * 3 + d;
      pos = $signed(p.pos[d]);
      vo = $signed(p.vold[d]);
      vn = $signed(p.vnew[d]);
      st = start_tab[at];
      case (cur_stage)
        rk4pa_pkg::STAGE0: begin
          k = scale_by_dt(vo, 16);
          start_tab[at] = pos[31:0];
          k0_tab[at] = k[31:0];
          nx = div_nearest(2 * pos + k, 2);
        end
        rk4pa_pkg::STAGE1: begin
          k = scale_by_dt(vo + vn, 17);
          k1_tab[at] = k[31:0];
          nx = div_nearest(2 * st + k, 2);
        end
        rk4pa_pkg::STAGE2: begin
          k = scale_by_dt(vo + vn, 17);
          k2_tab[at] = k[31:0];
          nx = sat32(st + k);
        end
        default: begin
          k = scale_by_dt(vn, 16);
          nx = div_nearest(6 * st + 64'(k0_tab[at]) + 2 * 64'(k1_tab[at])
                           + 2 * 64'(k2_tab[at]) + k, 6);
        end
      endcase
      o.nxt[d] = nx[31:0];
    end
    return o;
  endfunction

  function automatic logic [303:0] pack_particle(particle_t p);
    logic [303:0] w;
    w = '0;
    w[9:0] = p.index;
    for (int d = 0; d < 3; d++) begin
      w[10 + 32*d +: 32] = p.pos[d];
      w[106 + 32*d +: 32] = p.vold[d];
      w[202 + 32*d +: 32] = p.vnew[d];
    end
    return w;
  endfunction

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    in_acc <= s_axis_tvalid && s_axis_tready;
  end

  // Driver: one gap draw per word, valid held until accepted
  int gap_left;
  bit gap_drawn;
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 0;
      s_axis_tdata <= '0;
      gap_drawn <= 0;
    end else if (s_axis_tvalid && !in_acc) begin
      // hold the word
    end else if (pending_q.size() == 0) begin
      s_axis_tvalid <= 0;
    end else if (!gap_drawn) begin
      gap_left = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8));
      gap_drawn <= 1;
      if (gap_left == 0) begin
        s_axis_tdata <= pack_particle(pending_q[0]);
        expected_pos_q.push_back(advance_particle(pending_q.pop_front()));
        s_axis_tvalid <= 1;
        gap_drawn <= 0;
      end else begin
        s_axis_tvalid <= 0;
      end
    end else if (gap_left > 1) begin
      gap_left--;
      s_axis_tvalid <= 0;
    end else begin
      s_axis_tdata <= pack_particle(pending_q[0]);
      expected_pos_q.push_back(advance_particle(pending_q.pop_front()));
      s_axis_tvalid <= 1;
      gap_drawn <= 0;
    end
  end

  // Receiver ready: random stalls plus the long hold-off
  int stall_left;
  int hold_seen;
  int hold_left;
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 0;
      stall_left <= 0;
      hold_seen <= hold_req;
      hold_left <= 0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      m_axis_tready <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 0;
    end else if (m_axis_tready && m_axis_tvalid) begin
      stall_left <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 8) : 0;
      m_axis_tready <= 0;
    end else begin
      m_axis_tready <= 1;
    end
  end

  // Monitor and checker
  position_t got, want;
  always @(posedge clk) begin
    if (rst) begin
      watchdog <= 0;
    end else begin
      if ((s_axis_tvalid && s_axis_tready) || (cfg_valid && cfg_ready))
        watchdog <= 0;
      else if (m_axis_tvalid && m_axis_tready)
        watchdog <= 0;
      else
        watchdog <= watchdog + 1;
      if (m_axis_tvalid && m_axis_tready) begin
        got.index = m_axis_tdata[9:0];
        for (int d = 0; d < 3; d++) got.nxt[d] = m_axis_tdata[10 + 32*d +: 32];
        if (expected_pos_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected output word %h", m_axis_tdata);
        end else begin
          want = expected_pos_q.pop_front();
          if (got != want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch idx exp %0d got %0d | x %h/%h y %h/%h z %h/%h",
                       want.index, got.index, want.nxt[0], got.nxt[0],
                       want.nxt[1], got.nxt[1], want.nxt[2], got.nxt[2]);
          end
        end
      end
      if (watchdog >= WATCHDOG_LIMIT) begin
        $display("rk4_particle_advection_stage_unit_tb failed");
        $finish;
      end
    end
  end

  task automatic write_reg(logic idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == rk4pa_pkg::CFG_STAGE) cur_stage = val[1:0];
    else cur_dt = val;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 || expected_pos_q.size() != 0 || s_axis_tvalid)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_vel(int mode);
    case (mode)
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic particle_t rand_particle(logic [9:0] idx, bit wild);
    particle_t p;
    p.index = idx;
    for (int d = 0; d < 3; d++) begin
      p.pos[d] = wild ? $urandom : ($urandom_range(0, 32'h0200_0000) - 32'h0100_0000);
      p.vold[d] = rand_vel(wild ? $urandom_range(0, 3) : 2);
      p.vnew[d] = rand_vel(wild ? $urandom_range(0, 3) : 2);
    end
    return p;
  endfunction

  // One full RK4 step on a set of particles: four passes
  task automatic run_step(int count, logic [31:0] dt, bit wild, bit squeeze);
    logic [9:0] ids[$];
    int base;
    base = $urandom_range(0, NPART - 1);
    for (int i = 0; i < count; i++) ids.push_back(10'(base + i));
    write_reg(rk4pa_pkg::CFG_TIME_STEP, dt);
    for (int s = 0; s < 4; s++) begin
      write_reg(rk4pa_pkg::CFG_STAGE, 2'(s));
      ids.shuffle();
      foreach (ids[i]) pending_q.push_back(rand_particle(ids[i], wild));
      if (squeeze && s == 1) hold_req++;
      wait_drained();
    end
  endtask

  initial begin
    particle_t p;
    cfg_valid = 0;
    cfg_index = rk4pa_pkg::CFG_STAGE;
    cfg_data = '0;
    cur_stage = rk4pa_pkg::STAGE0;
    cur_dt = '0;
    rst = 1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: field extremes through all four stages, dt zero and maximum
    for (int dtsel = 0; dtsel < 2; dtsel++) begin
      write_reg(rk4pa_pkg::CFG_TIME_STEP, dtsel ? 32'hffff_ffff : 32'h0);
      for (int s = 0; s < 4; s++) begin
        write_reg(rk4pa_pkg::CFG_STAGE, 2'(s));
        for (int j = 0; j < 3; j++) begin
          p.index = (j == 0) ? 10'd0 : (j == 1) ? 10'd1023 : 10'd512;
          for (int d = 0; d < 3; d++) begin
            p.pos[d] = (j == 0) ? 32'h8000_0000 : (j == 1) ? 32'h7fff_ffff : 32'h0;
            p.vold[d] = (j == 0) ? 32'h8000_0000 : (j == 1) ? 32'h7fff_ffff : 32'h1_8000;
            p.vnew[d] = (j == 0) ? 32'h8000_0000 : (j == 1) ? 32'h7fff_ffff : 32'hffff_8000;
          end
          pending_q.push_back(p);
        end
        wait_drained();
      end
    end

    // Random: full steps on small sets, plus the long receiver stall
    run_step(40, 32'h0001_0000, 0, 1);
    repeat (14) begin
      run_step($urandom_range(1, 40),
               ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 32'h0004_0000),
               $urandom_range(0, 3) == 0, 0);
    end
    run_step(20, 32'h0000_8000, 1, 0);

    if (mismatches == 0 && expected_pos_q.size() == 0)
      $display("rk4_particle_advection_stage_unit_tb passed");
    else
      $display("rk4_particle_advection_stage_unit_tb failed");
    $finish;
  end
endmodule

[files.f]
design/rk4pa_pkg.sv
design/rk4pa_ram.sv
design/rk4pa_front.sv
design/rk4pa_queue.sv
design/rk4pa_back.sv
design/rk4_particle_advection_stage_unit.sv
test/rk4_particle_advection_stage_unit_tb.sv
